>>> src/fit_policy_block_search_core_defines.svh
// Assertion macros shared by the fit policy block search RTL.
`ifndef FIT_POLICY_BLOCK_SEARCH_CORE_DEFINES_SVH
`define FIT_POLICY_BLOCK_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTH

// Check that a property holds at every clock edge outside reset.
`define FPBS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Check that a condition never occurs outside reset.
`define FPBS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define FPBS_ASSERT(lbl, clk, rstn, prop)
`define FPBS_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> src/fpbs_pkg.sv
`timescale 1ns / 1ps

package fpbs_pkg;

  // Default table geometry
  localparam int unsigned MAX_BLOCKS_DEF = 64;
  localparam int unsigned SPACE_BITS_DEF = 16;

  // Field widths of the transactions
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned SIZE_W  = 16;

  // Configuration register widths
  localparam int unsigned POLICY_W = 2;
  localparam int unsigned BLOCKS_W = 7;
  localparam int unsigned CFG_W    = 7;

  // Configuration register indexes
  typedef enum logic {
    REG_FIT_POLICY    = 1'b0,
    REG_BLOCKS_IN_USE = 1'b1
  } cfg_reg_e;

  // Selection policies
  typedef enum logic [POLICY_W-1:0] {
    POLICY_BEST  = 2'd0,
    POLICY_FIRST = 2'd1,
    POLICY_WORST = 2'd2
  } fit_policy_e;

  // Operation codes of an input transaction
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef struct packed {
    logic              op;
    logic [INDEX_W-1:0] entry_index;
    logic [SIZE_W-1:0]  entry_free_space;
    logic [SIZE_W-1:0]  request_size;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] chosen_index;
  } out_item_t;

endpackage

>>> src/fpbs_stream_if.sv
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload per transaction.
interface fpbs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/fit_policy_block_search_core.sv
`timescale 1ns / 1ps

// Fit policy block search: holds the free space of up to MAX_BLOCKS memory
// blocks in a single-port synchronous table and, per search transaction, scans
// entries 0 .. blocks_in_use-1 to return the first, best or worst fitting
// block. A write transaction returns nothing. A search scans N entries, where
// N is blocks_in_use clamped to MAX_BLOCKS, and skips the scan when N is 0 or
// the policy code is unused: the table has one read port and the scan reads
// one entry per cycle, followed by a drain state to evaluate the last entry
// and a result state to load the result register. A new transaction is taken
// while the previous result still waits in the output register. Entries must
// be written before a search scans them.

`include "fit_policy_block_search_core_defines.svh"

module fit_policy_block_search_core #(
  parameter int unsigned MAX_BLOCKS = fpbs_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned SPACE_BITS = fpbs_pkg::SPACE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [fpbs_pkg::CFG_W-1:0]  cfg_wdata_i,
  fpbs_stream_if.sink                 in_i,
  fpbs_stream_if.source               out_o
);

  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CMP_W = (SPACE_BITS > fpbs_pkg::SIZE_W) ?
                                  SPACE_BITS : fpbs_pkg::SIZE_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [fpbs_pkg::POLICY_W-1:0] policy_q;
  logic [fpbs_pkg::BLOCKS_W-1:0] blocks_q;

  logic [SPACE_BITS-1:0] table_mem [MAX_BLOCKS];
  logic [SPACE_BITS-1:0] rdata_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [IDX_W-1:0]      addr_q;

  logic [fpbs_pkg::SIZE_W-1:0] req_q;
  logic                        have_q;
  logic [IDX_W-1:0]            pick_q;
  logic [SPACE_BITS-1:0]       pick_space_q;

  logic                  out_valid_q;
  fpbs_pkg::out_item_t   out_data_q;

  fpbs_pkg::in_item_t    in_item;
  logic                  in_acc;
  logic                  wr_en;
  logic                  search_start;
  logic                  policy_ok;
  logic                  last_addr;
  logic [CNT_W-1:0]      scan_cnt;
  logic                  qualifies;
  logic                  take;
  logic                  out_load;
  logic [31:0]           pick_ext;

  assign in_item = in_i.data;

  // Take transactions only between searches
  assign in_i.ready   = (state_q == ST_IDLE);
  assign in_acc       = in_i.valid && in_i.ready;
  assign wr_en        = in_acc && (in_item.op == fpbs_pkg::OP_WRITE) &&
                        (32'(in_item.entry_index) < MAX_BLOCKS);
  assign search_start = in_acc && (in_item.op == fpbs_pkg::OP_SEARCH);

  // Clamp the scan length to the table depth
  always_comb begin
    if (32'(blocks_q) > MAX_BLOCKS) begin
      scan_cnt = CNT_W'(MAX_BLOCKS);
    end else begin
      scan_cnt = CNT_W'(blocks_q);
    end
  end

  assign policy_ok = (policy_q == fpbs_pkg::POLICY_BEST) ||
                     (policy_q == fpbs_pkg::POLICY_FIRST) ||
                     (policy_q == fpbs_pkg::POLICY_WORST);
  assign last_addr = (32'(addr_q) == 32'(scan_cnt) - 32'd1);

  // Evaluate the entry returned by the table
  assign qualifies = CMP_W'(rdata_q) >= CMP_W'(req_q);
  assign take = rd_vld_q && qualifies &&
                (!have_q ||
                 ((policy_q == fpbs_pkg::POLICY_BEST) && (rdata_q < pick_space_q)) ||
                 ((policy_q == fpbs_pkg::POLICY_WORST) && (rdata_q > pick_space_q)));

  assign out_load = (state_q == ST_RESULT) && (!out_valid_q || out_o.ready);

  // Sequence the scan
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (search_start) begin
          if ((scan_cnt == '0) || !policy_ok) begin
            state_d = ST_RESULT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (last_addr) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Write and read the free space table
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[IDX_W'(in_item.entry_index)] <= SPACE_BITS'(in_item.entry_free_space);
    end
    if (state_q == ST_SCAN) begin
      rdata_q <= table_mem[addr_q];
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= '0;
      blocks_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fpbs_pkg::REG_FIT_POLICY:    policy_q <= cfg_wdata_i[fpbs_pkg::POLICY_W-1:0];
        fpbs_pkg::REG_BLOCKS_IN_USE: blocks_q <= cfg_wdata_i[fpbs_pkg::BLOCKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_vld_q    <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_SCAN);
      if (search_start) begin
        have_q <= 1'b0;
      end else if (take) begin
        have_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Track scan address, request and current pick
  always_ff @(posedge clk_i) begin
    if (search_start) begin
      addr_q <= '0;
      req_q  <= in_item.request_size;
    end else if (state_q == ST_SCAN) begin
      addr_q <= addr_q + IDX_W'(1);
    end
    if (state_q == ST_SCAN) begin
      rd_idx_q <= addr_q;
    end
    if (take) begin
      pick_q       <= rd_idx_q;
      pick_space_q <= rdata_q;
    end
  end

  // Load the result register
  assign pick_ext = 32'(pick_q);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.found        <= have_q;
      out_data_q.chosen_index <= have_q ? pick_ext[fpbs_pkg::INDEX_W-1:0] : '0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  `FPBS_ASSERT(a_rd_only_scan, clk_i, rst_ni,
    rd_vld_q |-> ((state_q == ST_SCAN) || (state_q == ST_DRAIN)))
  `FPBS_ASSERT(a_drain_has_data, clk_i, rst_ni,
    (state_q == ST_DRAIN) |-> rd_vld_q)
  `FPBS_ASSERT(a_out_from_result, clk_i, rst_ni,
    $rose(out_valid_q) |-> ($past(state_q) == ST_RESULT))
  `FPBS_ASSERT(a_pick_in_range, clk_i, rst_ni,
    (have_q && (state_q != ST_IDLE)) |-> (32'(pick_q) < 32'(scan_cnt)))
  `FPBS_ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni,
    in_acc && (rd_vld_q || (state_q == ST_RESULT)))

endmodule
